>>> rtl/core/cpha_pkg.sv
// ----------------------------------------------------------------------------
// Colour palette hash allocator: shared definitions
// Table sizes, status codes, controller states, the memory request bundle
// and the reset contents of the bucket and entry tables.
// ----------------------------------------------------------------------------
`default_nettype none

package cpha_pkg;

  localparam int PALETTE_ENTRIES = 544;
  localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
  localparam int RGB_W           = 24;
  localparam int CHAN_W          = 8;
  localparam int ST_W            = 2;

  localparam logic [IDX_W-1:0] FIRST_FREE_INDEX = IDX_W'(32);
  localparam logic [IDX_W-1:0] FULL_LIMIT       = IDX_W'(543);
  localparam logic [IDX_W-1:0] LAST_ENTRY       = IDX_W'(PALETTE_ENTRIES - 1);

  // Per-channel hash masks.
  localparam logic [CHAN_W-1:0] RED_MASK   = 8'd255;
  localparam logic [CHAN_W-1:0] GREEN_MASK = 8'd161;
  localparam logic [CHAN_W-1:0] BLUE_MASK  = 8'd127;

  localparam logic [ST_W-1:0] ST_FOUND = 2'd0;
  localparam logic [ST_W-1:0] ST_NEW   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_LINK,
    S_RESULT
  } ctl_state_t;

  typedef struct packed {
    logic [RGB_W-1:0] rgb;
    logic [IDX_W-1:0] link;
  } entry_t;

  typedef struct packed {
    logic             bkt_rd;
    logic             bkt_we;
    logic [IDX_W-1:0] bkt_addr;
    logic [IDX_W-1:0] bkt_wdata;
    logic             ent_rd;
    logic             ent_we;
    logic [IDX_W-1:0] ent_addr;
    entry_t           ent_wdata;
  } mem_req_t;

  // Bucket heads after reset: the seven primaries other than black sit in their own buckets.
  function automatic logic [IDX_W-1:0] preload_head(input logic [IDX_W-1:0] bucket);
    logic [IDX_W-1:0] head;
    head = '0;
    case (bucket)
      IDX_W'(127): head = IDX_W'(1);
      IDX_W'(161): head = IDX_W'(2);
      IDX_W'(288): head = IDX_W'(3);
      IDX_W'(255): head = IDX_W'(4);
      IDX_W'(382): head = IDX_W'(5);
      IDX_W'(416): head = IDX_W'(6);
      IDX_W'(543): head = IDX_W'(7);
      default:     head = '0;
    endcase
    return head;
  endfunction

  // Colours of the preloaded entries, red in the top byte.
  function automatic logic [RGB_W-1:0] preload_rgb(input logic [IDX_W-1:0] idx);
    logic [RGB_W-1:0] rgb;
    rgb = '0;
    case (idx)
      IDX_W'(1): rgb = 24'h0000FF;
      IDX_W'(2): rgb = 24'h00FF00;
      IDX_W'(3): rgb = 24'h00FFFF;
      IDX_W'(4): rgb = 24'hFF0000;
      IDX_W'(5): rgb = 24'hFF00FF;
      IDX_W'(6): rgb = 24'hFFFF00;
      IDX_W'(7): rgb = 24'hFFFFFF;
      default:   rgb = '0;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cpha_store.sv
// ----------------------------------------------------------------------------
// Palette table storage
// Bucket head memory and entry memory (colour plus chain link), both with a
// registered read. After reset a sweep writes the preload contents
// into every address before the store reports ready.
// ----------------------------------------------------------------------------
`default_nettype none

module cpha_store (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cpha_pkg::mem_req_t        req,
  output logic                           ready,
  output logic [cpha_pkg::IDX_W-1:0]     bkt_rdata,
  output cpha_pkg::entry_t               ent_rdata
);

  logic [cpha_pkg::IDX_W-1:0] bkt_mem [cpha_pkg::PALETTE_ENTRIES];
  cpha_pkg::entry_t           ent_mem [cpha_pkg::PALETTE_ENTRIES];

  logic [cpha_pkg::IDX_W-1:0] clr_cnt_r;
  logic [cpha_pkg::IDX_W-1:0] clr_cnt_nxt;
  logic                       clr_busy_r;
  logic                       clr_busy_nxt;

  logic                       bkt_we;
  logic [cpha_pkg::IDX_W-1:0] bkt_waddr;
  logic [cpha_pkg::IDX_W-1:0] bkt_wdata;
  logic                       ent_we;
  logic [cpha_pkg::IDX_W-1:0] ent_waddr;
  cpha_pkg::entry_t           ent_wdata;

  assign ready = ~clr_busy_r;

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == cpha_pkg::LAST_ENTRY) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // The sweep owns the write ports until it is done.
  always_comb begin
    if (clr_busy_r) begin
      bkt_we         = 1'b1;
      bkt_waddr      = clr_cnt_r;
      bkt_wdata      = cpha_pkg::preload_head(clr_cnt_r);
      ent_we         = 1'b1;
      ent_waddr      = clr_cnt_r;
      ent_wdata.rgb  = cpha_pkg::preload_rgb(clr_cnt_r);
      ent_wdata.link = '0;
    end else begin
      bkt_we    = req.bkt_we;
      bkt_waddr = req.bkt_addr;
      bkt_wdata = req.bkt_wdata;
      ent_we    = req.ent_we;
      ent_waddr = req.ent_addr;
      ent_wdata = req.ent_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    if (req.bkt_rd) begin
      bkt_rdata <= bkt_mem[req.bkt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (req.ent_rd) begin
      ent_rdata <= ent_mem[req.ent_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/colour_palette_hash_allocator.sv
// ----------------------------------------------------------------------------
// Colour palette hash allocator
// Maps an RGB colour to a palette index through a hashed bucket table with
// chained entries, allocating a new entry when the colour is not present.
//
//   Channel | Ports         | Direction | Contents
//   --------+---------------+-----------+---------------------------------
//   input   | in_tvalid/..  | slave     | red, green, blue
//   result  | out_tvalid/.. | master    | palette_index, status
//
// Black at hash 0 is answered without reading the tables. Otherwise the
// bucket head is read first and then each chain entry visited is read on
// the entry memory port; an append to a chain tail needs a second entry
// write. After reset a sweep loads the tables; no input is accepted
// meanwhile. A result waits in the output register while the next item is
// taken; the controller only stalls if a second result is ready first.
// ----------------------------------------------------------------------------
`default_nettype none

module colour_palette_hash_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // palette_index [9:0], status [11:10], zero
);

  localparam int IDX_W  = cpha_pkg::IDX_W;
  localparam int RGB_W  = cpha_pkg::RGB_W;
  localparam int CHAN_W = cpha_pkg::CHAN_W;
  localparam int ST_W   = cpha_pkg::ST_W;

  cpha_pkg::ctl_state_t state_r;
  cpha_pkg::ctl_state_t state_nxt;
  cpha_pkg::mem_req_t   req;

  logic                  store_ready;
  logic [IDX_W-1:0]      bkt_rdata;
  cpha_pkg::entry_t      ent_rdata;

  logic [RGB_W-1:0]      rgb_r;
  logic [IDX_W-1:0]      hash_r;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      idx_nxt;
  logic [IDX_W-1:0]      free_r;
  logic [IDX_W-1:0]      free_nxt;
  logic [IDX_W-1:0]      res_idx_r;
  logic [IDX_W-1:0]      res_idx_nxt;
  logic [ST_W-1:0]       res_st_r;
  logic [ST_W-1:0]       res_st_nxt;
  logic                  out_valid_r;
  logic [IDX_W-1:0]      out_idx_r;
  logic [ST_W-1:0]       out_st_r;
  logic                  out_load;

  logic [CHAN_W-1:0]     in_red;
  logic [CHAN_W-1:0]     in_green;
  logic [CHAN_W-1:0]     in_blue;
  logic [RGB_W-1:0]      in_rgb;
  logic [IDX_W-1:0]      in_hash;
  logic                  in_accept;
  logic                  has_room;

  assign in_red   = in_tdata[7:0];
  assign in_green = in_tdata[15:8];
  assign in_blue  = in_tdata[23:16];
  assign in_rgb   = {in_red, in_green, in_blue};
  assign in_hash  = IDX_W'(in_red & cpha_pkg::RED_MASK)
                  + IDX_W'(in_green & cpha_pkg::GREEN_MASK)
                  + IDX_W'(in_blue & cpha_pkg::BLUE_MASK);
  assign in_accept = in_tvalid & in_tready;
  assign has_room  = (free_r < cpha_pkg::FULL_LIMIT);

  cpha_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .ready     (store_ready),
    .bkt_rdata (bkt_rdata),
    .ent_rdata (ent_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    req         = '0;
    idx_nxt     = idx_r;
    free_nxt    = free_r;
    res_idx_nxt = res_idx_r;
    res_st_nxt  = res_st_r;
    in_tready   = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      cpha_pkg::S_CLEAR: begin
        if (store_ready) begin
          state_nxt = cpha_pkg::S_IDLE;
        end
      end
      cpha_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          // Entry 0 always holds black, so the shortcut needs no read.
          if (in_hash == '0 && in_rgb == '0) begin
            res_idx_nxt = '0;
            res_st_nxt  = cpha_pkg::ST_FOUND;
            state_nxt   = cpha_pkg::S_RESULT;
          end else begin
            req.bkt_rd   = 1'b1;
            req.bkt_addr = in_hash;
            state_nxt    = cpha_pkg::S_HEAD;
          end
        end
      end
      cpha_pkg::S_HEAD: begin
        if (bkt_rdata == '0) begin
          if (has_room) begin
            req.bkt_we          = 1'b1;
            req.bkt_addr        = hash_r;
            req.bkt_wdata       = free_r;
            req.ent_we          = 1'b1;
            req.ent_addr        = free_r;
            req.ent_wdata.rgb   = rgb_r;
            req.ent_wdata.link  = '0;
            free_nxt            = free_r + 1'b1;
            res_idx_nxt         = free_r;
            res_st_nxt          = cpha_pkg::ST_NEW;
          end else begin
            res_idx_nxt = '0;
            res_st_nxt  = cpha_pkg::ST_FULL;
          end
          state_nxt = cpha_pkg::S_RESULT;
        end else begin
          req.ent_rd   = 1'b1;
          req.ent_addr = bkt_rdata;
          idx_nxt      = bkt_rdata;
          state_nxt    = cpha_pkg::S_WALK;
        end
      end
      cpha_pkg::S_WALK: begin
        if (ent_rdata.rgb == rgb_r) begin
          res_idx_nxt = idx_r;
          res_st_nxt  = cpha_pkg::ST_FOUND;
          state_nxt   = cpha_pkg::S_RESULT;
        end else if (ent_rdata.link == '0) begin
          if (has_room) begin
            // Point the chain tail at the new entry; the entry itself is
            // written in the next cycle.
            req.ent_we         = 1'b1;
            req.ent_addr       = idx_r;
            req.ent_wdata.rgb  = ent_rdata.rgb;
            req.ent_wdata.link = free_r;
            res_idx_nxt        = free_r;
            res_st_nxt         = cpha_pkg::ST_NEW;
            state_nxt          = cpha_pkg::S_LINK;
          end else begin
            res_idx_nxt = '0;
            res_st_nxt  = cpha_pkg::ST_FULL;
            state_nxt   = cpha_pkg::S_RESULT;
          end
        end else begin
          req.ent_rd   = 1'b1;
          req.ent_addr = ent_rdata.link;
          idx_nxt      = ent_rdata.link;
        end
      end
      cpha_pkg::S_LINK: begin
        req.ent_we         = 1'b1;
        req.ent_addr       = res_idx_r;
        req.ent_wdata.rgb  = rgb_r;
        req.ent_wdata.link = '0;
        free_nxt           = free_r + 1'b1;
        state_nxt          = cpha_pkg::S_RESULT;
      end
      cpha_pkg::S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = cpha_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cpha_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpha_pkg::S_CLEAR;
      free_r      <= cpha_pkg::FIRST_FREE_INDEX;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rgb_r  <= in_rgb;
      hash_r <= in_hash;
    end
    idx_r     <= idx_nxt;
    res_idx_r <= res_idx_nxt;
    res_st_r  <= res_st_nxt;
    if (out_load) begin
      out_idx_r <= res_idx_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_st_r, out_idx_r};

endmodule

`default_nettype wire
